// ----- rtl/cspk_pkg.sv -----
// Shared types and constants for the code and symbol bit packer.
package cspk_pkg;

    // Field widths of the input and result items.
    localparam int CODE_W      = 16;
    localparam int CODE_BITS_W = 5;
    localparam int BYTE_W      = 8;
    localparam int RES_W       = 7;
    localparam int RES_CNT_W   = 3;
    localparam int ACC_W       = 31;
    localparam int TOTAL_W     = 5;
    localparam int RUN_BYTES   = 3;
    localparam int RUN_CNT_W   = 2;

    // Run queue depth; a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = QPTR_W + 1;

    // Operation codes of an input item.
    localparam logic OP_PAIR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // One run of completed bytes caused by a single input item.
    typedef struct packed {
        logic [RUN_CNT_W-1:0]              count;
        logic [RUN_BYTES-1:0][BYTE_W-1:0] bytes;
    } t_run;

    // Push side of the run queue.
    typedef struct packed {
        logic valid;
        t_run run;
    } t_push;

    // Pop side of the run queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_run run;
    } t_head;

endpackage

// ----- rtl/cspk_front.sv -----
// Front end: accepts items, packs them onto the residual and forms byte runs.
module cspk_front #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_queue_full,
    input  logic                             i_operation,
    input  logic [cspk_pkg::CODE_W-1:0]      i_code,
    input  logic [cspk_pkg::CODE_BITS_W-1:0] i_code_bits,
    input  logic [cspk_pkg::BYTE_W-1:0]      i_symbol,
    output cspk_pkg::t_push                  o_push
);

    logic [cspk_pkg::RES_W-1:0]       r_res_bits;
    logic [cspk_pkg::RES_CNT_W-1:0]   r_res_cnt;
    logic [cspk_pkg::RES_W-1:0]       n_res_bits;
    logic [cspk_pkg::RES_CNT_W-1:0]   n_res_cnt;
    logic                             accept;
    logic [cspk_pkg::CODE_BITS_W-1:0] nbits;
    logic [cspk_pkg::CODE_W-1:0]      code_mask;
    logic [cspk_pkg::CODE_W-1:0]      code_m;
    logic [cspk_pkg::ACC_W-1:0]       acc;
    logic [cspk_pkg::TOTAL_W-1:0]     total;
    logic [cspk_pkg::RUN_CNT_W-1:0]   nbytes;
    logic [cspk_pkg::RES_W-1:0]       pair_res;

    assign accept = i_in_valid && !i_queue_full;

    // Saturate the code width and keep only the used code bits.
    always_comb begin
        if (i_code_bits > cspk_pkg::CODE_BITS_W'(MAX_CODE_BITS)) begin
            nbits = cspk_pkg::CODE_BITS_W'(MAX_CODE_BITS);
        end else begin
            nbits = i_code_bits;
        end
        code_mask = ~({cspk_pkg::CODE_W{1'b1}} << nbits);
        code_m    = i_code & code_mask;
    end

    // Append code then symbol above the residual; bits above the total stay zero.
    always_comb begin
        acc = cspk_pkg::ACC_W'(r_res_bits)
            | (cspk_pkg::ACC_W'(code_m) << r_res_cnt)
            | (cspk_pkg::ACC_W'(i_symbol) << (cspk_pkg::TOTAL_W'(r_res_cnt) + nbits));
        total  = cspk_pkg::TOTAL_W'(r_res_cnt) + nbits
               + cspk_pkg::TOTAL_W'(cspk_pkg::BYTE_W);
        nbytes = total[cspk_pkg::TOTAL_W-1:cspk_pkg::RES_CNT_W];
        case (nbytes)
            2'd1:    pair_res = acc[14:8];
            2'd2:    pair_res = acc[22:16];
            2'd3:    pair_res = acc[30:24];
            default: pair_res = '0;
        endcase
    end

    // Build the run for the queue and the next residual.
    always_comb begin
        o_push     = '0;
        n_res_bits = r_res_bits;
        n_res_cnt  = r_res_cnt;
        if (accept) begin
            if (i_operation == cspk_pkg::OP_FLUSH) begin
                // A flush with an empty residual produces no byte.
                o_push.valid        = (r_res_cnt != '0);
                o_push.run.count    = cspk_pkg::RUN_CNT_W'(1);
                o_push.run.bytes[0] = cspk_pkg::BYTE_W'(r_res_bits);
                n_res_bits          = '0;
                n_res_cnt           = '0;
            end else begin
                o_push.valid        = 1'b1;
                o_push.run.count    = nbytes;
                o_push.run.bytes[0] = acc[7:0];
                o_push.run.bytes[1] = acc[15:8];
                o_push.run.bytes[2] = acc[23:16];
                n_res_bits          = pair_res;
                n_res_cnt           = total[cspk_pkg::RES_CNT_W-1:0];
            end
        end
    end

    // Residual state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits <= '0;
            r_res_cnt  <= '0;
        end else begin
            r_res_bits <= n_res_bits;
            r_res_cnt  <= n_res_cnt;
        end
    end

endmodule

// ----- rtl/cspk_queue.sv -----
// Short run queue between the front end and the back end.
module cspk_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cspk_pkg::t_push i_push,
    input  logic            i_pop,
    output cspk_pkg::t_head o_head,
    output logic            o_full
);

    cspk_pkg::t_run                  r_mem [cspk_pkg::QUEUE_DEPTH];
    logic [cspk_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [cspk_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [cspk_pkg::QFILL_W-1:0]    r_fill;
    logic [cspk_pkg::QFILL_W-1:0]    n_fill;
    logic                            do_pop;

    assign do_pop = i_pop && (r_fill != '0);
    assign o_full = (r_fill == cspk_pkg::QFILL_W'(cspk_pkg::QUEUE_DEPTH));

    // Head of the queue for the back end.
    assign o_head.valid = (r_fill != '0);
    assign o_head.run   = r_mem[r_rd_ptr];

    // Fill level follows pushes and pops.
    always_comb begin
        n_fill = r_fill;
        if (i_push.valid && !do_pop) begin
            n_fill = r_fill + cspk_pkg::QFILL_W'(1);
        end else if (!i_push.valid && do_pop) begin
            n_fill = r_fill - cspk_pkg::QFILL_W'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + cspk_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cspk_pkg::QPTR_W'(1);
            end
            r_fill <= n_fill;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.run;
        end
    end

endmodule

// ----- rtl/cspk_back.sv -----
// Back end: sends each run's bytes, one per cycle unless stalled, via an output register.
module cspk_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cspk_pkg::t_head             i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [cspk_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last_of_run
);

    logic [cspk_pkg::RUN_CNT_W-1:0] r_idx;
    logic                           r_out_valid;
    logic [cspk_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_out_last;
    logic                           load;
    logic                           is_last;

    // The output register takes a new byte whenever it is empty or being taken.
    assign load    = i_head.valid && (!r_out_valid || !i_out_stall);
    assign is_last = ((r_idx + cspk_pkg::RUN_CNT_W'(1)) == i_head.run.count);
    assign o_pop   = load && is_last;

    // Byte index within the head run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= is_last ? '0 : r_idx + cspk_pkg::RUN_CNT_W'(1);
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.run.bytes[r_idx];
            r_out_last <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

// ----- rtl/code_symbol_bit_packer.sv -----
// Top level of the code and symbol bit packer: front end, run queue and back end.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_stall   i_operation, i_code, i_code_bits, i_symbol
//   output   out        o_out_valid / i_out_stall o_out_byte, o_last_of_run
//
// An item can be accepted every cycle while the run queue is not full; it yields zero to
// three bytes, and the back end sends one byte per cycle while the output is not stalled.
// The first byte of an item passes through the run queue and then the output register.
// The input stalls only when the two-entry run queue is full.
// Reset is synchronous and clears the residual, the queue and the output valid flag.
module code_symbol_bit_packer #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic [cspk_pkg::CODE_W-1:0]      i_code,
    input  logic [cspk_pkg::CODE_BITS_W-1:0] i_code_bits,
    input  logic [cspk_pkg::BYTE_W-1:0]      i_symbol,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [cspk_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                             o_last_of_run
);

    cspk_pkg::t_push push;
    cspk_pkg::t_head head;
    logic            queue_full;
    logic            pop;

    assign o_in_stall = queue_full;

    // Packing of items into byte runs.
    cspk_front #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_queue_full(queue_full),
        .i_operation (i_operation),
        .i_code      (i_code),
        .i_code_bits (i_code_bits),
        .i_symbol    (i_symbol),
        .o_push      (push)
    );

    // Runs waiting for the back end.
    cspk_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_head (head),
        .o_full (queue_full)
    );

    // Byte sender.
    cspk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

endmodule

// ----- rtl/cspk_checker.sv -----
// Port-level checks of the code and symbol bit packer, bound to the top level.
module cspk_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [cspk_pkg::BYTE_W-1:0] o_out_byte,
    input logic                        o_last_of_run
);

    // A stalled byte stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output item dropped while stalled");

    // A stalled byte keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("output payload changed while stalled");

    // Reset empties the output register and opens the input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output valid or input stall after reset");

    // The input stalls only when a byte is waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with nothing at the output");

endmodule

bind code_symbol_bit_packer cspk_checker u_cspk_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the code and symbol bit packer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CODE_BITS = 16;
    localparam int RANDOM_ITEMS  = 260;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES   = 16;
    localparam int HOLD_AT_ITEM  = 60;
    localparam int HOLD_CYCLES   = 120;
    localparam int MODE_PERIOD   = 64;

    // One input item, plus a flag that makes the sender wait for all bytes first.
    typedef struct {
        logic                             operation;
        logic [cspk_pkg::CODE_W-1:0]      code;
        logic [cspk_pkg::CODE_BITS_W-1:0] code_bits;
        logic [cspk_pkg::BYTE_W-1:0]      symbol;
        bit                               drain_first;
    } t_packer_item;

    // One packed byte as the block should deliver it.
    typedef struct {
        logic [cspk_pkg::BYTE_W-1:0] out_byte;
        logic                        last_of_run;
    } t_packed_byte;

    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             in_valid      = 1'b0;
    logic                             in_operation  = cspk_pkg::OP_PAIR;
    logic [cspk_pkg::CODE_W-1:0]      in_code       = '0;
    logic [cspk_pkg::CODE_BITS_W-1:0] in_code_bits  = '0;
    logic [cspk_pkg::BYTE_W-1:0]      in_symbol     = '0;
    logic                             out_stall     = 1'b0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [cspk_pkg::BYTE_W-1:0]      o_out_byte;
    logic                             o_last_of_run;

    t_packer_item stream_items[$];
    t_packed_byte pending_bytes[$];
    t_packer_item offered;

    // Predicted bit residual of the packer.
    logic [31:0] residual_bits  = '0;
    int          residual_count = 0;

    int error_count    = 0;
    int accepted_items = 0;
    int total_items    = 0;
    int cycle_count    = 0;

    code_symbol_bit_packer #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (in_operation),
        .i_code       (in_code),
        .i_code_bits  (in_code_bits),
        .i_symbol     (in_symbol),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Appends the bytes that one accepted item completes and updates the residual.
    task automatic predict_packed_bytes(input t_packer_item it);
        int           width;
        int           total;
        int           nbytes;
        logic [31:0]  masked_code;
        logic [31:0]  acc;
        t_packed_byte pb;
        if (it.operation == cspk_pkg::OP_FLUSH) begin
            // An empty residual flushes to nothing; otherwise pad with zeros.
            if (residual_count != 0) begin
                pb.out_byte    = residual_bits[cspk_pkg::BYTE_W-1:0];
                pb.last_of_run = 1'b1;
                pending_bytes.push_back(pb);
                residual_bits  = '0;
                residual_count = 0;
            end
        end else begin
            width = int'(it.code_bits);
            if (width > MAX_CODE_BITS) begin
                width = MAX_CODE_BITS;
            end
            masked_code = 32'(it.code) & ((32'd1 << width) - 32'd1);
            acc = residual_bits
                | (masked_code << residual_count)
                | (32'(it.symbol) << (residual_count + width));
            total  = residual_count + width + cspk_pkg::BYTE_W;
            nbytes = total / cspk_pkg::BYTE_W;
            for (int k = 0; k < nbytes; k++) begin
                pb.out_byte    = acc[k*cspk_pkg::BYTE_W +: cspk_pkg::BYTE_W];
                pb.last_of_run = (k == nbytes - 1);
                pending_bytes.push_back(pb);
            end
            residual_count = total % cspk_pkg::BYTE_W;
            residual_bits  = (acc >> (nbytes * cspk_pkg::BYTE_W))
                           & ((32'd1 << residual_count) - 32'd1);
        end
    endtask

    // Idle length for one side; mode 0 never idles, mode 2 idles most.
    function automatic int idle_length(input int mode);
        int roll;
        roll = $urandom_range(99);
        if (mode == 0 || (mode == 1 && roll < 70) || (mode == 2 && roll < 30)) begin
            return 0;
        end
        if (roll >= 96) begin
            return $urandom_range(30, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic t_packer_item pair_item(
        input logic [cspk_pkg::CODE_W-1:0]      code,
        input logic [cspk_pkg::CODE_BITS_W-1:0] code_bits,
        input logic [cspk_pkg::BYTE_W-1:0]      symbol);
        t_packer_item it;
        it.operation   = cspk_pkg::OP_PAIR;
        it.code        = code;
        it.code_bits   = code_bits;
        it.symbol      = symbol;
        it.drain_first = 1'b0;
        return it;
    endfunction

    // Flush items carry random contents in the fields the block ignores.
    function automatic t_packer_item flush_item();
        t_packer_item it;
        it.operation   = cspk_pkg::OP_FLUSH;
        it.code        = cspk_pkg::CODE_W'($urandom());
        it.code_bits   = cspk_pkg::CODE_BITS_W'($urandom());
        it.symbol      = cspk_pkg::BYTE_W'($urandom());
        it.drain_first = 1'b0;
        return it;
    endfunction

    // Sender: offers queued items, holds them while stalled, idles at random.
    always @(posedge i_clk) begin : sender
        int in_gap;
        int in_mode;
        int in_phase;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   = 0;
            in_mode  = 0;
            in_phase = 0;
        end else begin
            in_phase++;
            if (in_phase >= MODE_PERIOD) begin
                in_phase = 0;
                in_mode  = $urandom_range(2);
            end
            if (in_valid && !o_in_stall) begin
                predict_packed_bytes(offered);
                accepted_items++;
                in_gap = idle_length(in_mode);
            end
            if (in_valid && o_in_stall) begin
                // Stalled: keep the item on the port unchanged.
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (stream_items.size() != 0 &&
                         !(stream_items[0].drain_first && pending_bytes.size() != 0)) begin
                offered = stream_items.pop_front();
                in_operation <= offered.operation;
                in_code      <= offered.code;
                in_code_bits <= offered.code_bits;
                in_symbol    <= offered.symbol;
                in_valid     <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to fill the block.
    always @(posedge i_clk) begin : receiver
        int  stall_left;
        int  out_mode;
        int  out_phase;
        bit  hold_done;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            out_mode   = 0;
            out_phase  = 0;
            hold_done  = 1'b0;
        end else begin
            out_phase++;
            if (out_phase >= MODE_PERIOD) begin
                out_phase = 0;
                out_mode  = $urandom_range(2);
            end
            if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0) begin
                stall_left = idle_length(out_mode);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor: compares every delivered byte with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_packed_byte want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte 0x%02h", o_out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    flag_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                            o_out_byte, want.out_byte));
                end
                if (o_last_of_run !== want.last_of_run) begin
                    flag_mismatch($sformatf("last_of_run %0b, expected %0b",
                                            o_last_of_run, want.last_of_run));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : run_control
        t_packer_item it;
        int           roll;
        int           width;
        int           settle;

        // Directed part: field extremes, odd code widths, flushes full and empty.
        stream_items.push_back(pair_item(16'h0000, 5'd1, 8'h00));
        stream_items.push_back(pair_item(16'hFFFF, 5'd16, 8'hFF));
        stream_items.push_back(pair_item(16'hA5A5, 5'd0, 8'h3C));
        stream_items.push_back(pair_item(16'hFFFF, 5'd31, 8'h00));
        stream_items.push_back(pair_item(16'h1234, 5'd17, 8'h81));
        stream_items.push_back(flush_item());
        stream_items.push_back(flush_item());
        stream_items.push_back(pair_item(16'h007F, 5'd7, 8'h55));
        stream_items.push_back(pair_item(16'hFFFF, 5'd16, 8'hFF));
        stream_items.push_back(flush_item());
        stream_items.push_back(pair_item(16'h0000, 5'd8, 8'h00));
        stream_items.push_back(flush_item());
        stream_items.push_back(pair_item(16'hFFFF, 5'd1, 8'hFF));
        stream_items.push_back(pair_item(16'h8001, 5'd16, 8'h7E));
        stream_items.push_back(pair_item(16'h5555, 5'd24, 8'hAA));
        stream_items.push_back(pair_item(16'hFFFE, 5'd15, 8'h01));
        stream_items.push_back(flush_item());

        // Random part: mostly pairs of legal width, some zero and oversized widths.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                it = flush_item();
            end else begin
                roll = $urandom_range(99);
                if (roll < 5) begin
                    width = 0;
                end else if (roll < 12) begin
                    width = $urandom_range(31, 17);
                end else begin
                    width = $urandom_range(16, 1);
                end
                it = pair_item(cspk_pkg::CODE_W'($urandom()),
                               cspk_pkg::CODE_BITS_W'(width),
                               cspk_pkg::BYTE_W'($urandom()));
            end
            it.drain_first = (n == 0) || (n >= 90 && $urandom_range(59) == 0);
            stream_items.push_back(it);
        end
        total_items = stream_items.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items < total_items) begin
            @(posedge i_clk);
        end
        settle = 0;
        while (pending_bytes.size() != 0 && settle < SETTLE_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            flag_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- code_symbol_bit_packer.f -----
rtl/cspk_pkg.sv
rtl/cspk_front.sv
rtl/cspk_queue.sv
rtl/cspk_back.sv
rtl/code_symbol_bit_packer.sv
rtl/cspk_checker.sv
verif/tb.sv
